[src/lom_pkg.sv]
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types for the limit order matcher: one queued order.
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam int unsigned FieldWidth = 32;

    typedef struct packed {
        logic                  is_buy;
        logic [FieldWidth-1:0] limit_price;
        logic [FieldWidth-1:0] order_qty;
        logic [FieldWidth-1:0] order_id;
        logic                  zero_qty;
    } t_order;

endpackage

[src/lom_front.sv]
// ----------------------------------------------------------------------------
// lom_front
// Accepts orders, flags zero-quantity orders and holds them in a two-entry
// queue in front of the matching engine.
// ----------------------------------------------------------------------------
module lom_front import lom_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_is_buy,
    input  logic [FieldWidth-1:0] i_limit_price,
    input  logic [FieldWidth-1:0] i_order_qty,
    input  logic [FieldWidth-1:0] i_order_id,
    input  logic                  i_pop,
    output logic                  o_head_valid,
    output t_order                o_head
);

    t_order     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_in_stall   = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_mem[r_rp];
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_pop && o_head_valid;

    // queue storage, order classified on entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{is_buy: i_is_buy, limit_price: i_limit_price,
                             order_qty: i_order_qty, order_id: i_order_id,
                             zero_qty: (i_order_qty == '0)};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/lom_back.sv]
// ----------------------------------------------------------------------------
// lom_back
// Matching engine: slot table, best-maker scan one slot a cycle, fills,
// resting of the remainder and the summary beat, behind an output register.
// ----------------------------------------------------------------------------
module lom_back import lom_pkg::*; #(
    parameter int unsigned ORDER_SLOTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  t_order                i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FieldWidth-1:0] o_taker_id,
    output logic [FieldWidth-1:0] o_maker_id,
    output logic [FieldWidth-1:0] o_fill_price,
    output logic [FieldWidth-1:0] o_fill_qty,
    output logic [FieldWidth-1:0] o_remaining_qty,
    output logic                  o_rested,
    output logic                  o_dropped,
    output logic                  o_last
);

    localparam int unsigned IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int unsigned CW = $clog2(ORDER_SLOTS + 1);
    localparam logic [CW-1:0] LastCnt = CW'(ORDER_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;

    // slot table
    logic                  r_valid   [ORDER_SLOTS];
    logic                  m_buy     [ORDER_SLOTS];
    logic [FieldWidth-1:0] m_price   [ORDER_SLOTS];
    logic [FieldWidth-1:0] m_qty     [ORDER_SLOTS];
    logic [FieldWidth-1:0] m_id      [ORDER_SLOTS];
    logic [FieldWidth-1:0] m_arr     [ORDER_SLOTS];
    logic [FieldWidth-1:0] r_arr_cnt;

    // current taker
    logic                  r_buy;
    logic [FieldWidth-1:0] r_limit;
    logic [FieldWidth-1:0] r_rem;
    logic [FieldWidth-1:0] r_tid;

    // scan
    logic [CW-1:0]         r_idx;
    logic                  r_cv;
    logic [IW-1:0]         r_cidx;
    logic                  r_rd_valid;
    logic                  r_rd_buy;
    logic [FieldWidth-1:0] r_rd_price;
    logic [FieldWidth-1:0] r_rd_qty;
    logic [FieldWidth-1:0] r_rd_id;
    logic [FieldWidth-1:0] r_rd_arr;

    logic                  r_bfound;
    logic [IW-1:0]         r_bidx;
    logic [FieldWidth-1:0] r_bprice;
    logic [FieldWidth-1:0] r_bage;
    logic [FieldWidth-1:0] r_bqty;
    logic [FieldWidth-1:0] r_bid;

    // output register
    logic                  r_ov;
    logic [FieldWidth-1:0] r_o_taker, r_o_maker, r_o_price, r_o_qty, r_o_rem;
    logic                  r_o_rested, r_o_dropped, r_o_last;

    logic                  w_can_emit;
    logic                  w_cand;
    logic                  w_better;
    logic [FieldWidth-1:0] w_age;
    logic [FieldWidth-1:0] w_q;
    logic [FieldWidth-1:0] w_new_rem;
    logic [FieldWidth-1:0] w_maker_left;
    logic                  w_free_found;
    logic [IW-1:0]         w_free_idx;
    logic                  w_fill_we;
    logic                  w_rest_we;

    assign w_can_emit = !r_ov || !i_out_stall;
    assign o_pop      = (r_state == S_IDLE) && i_head_valid;

    // candidate test and priority compare
    always_comb begin
        w_age  = r_arr_cnt - r_rd_arr;
        w_cand = r_rd_valid && (r_rd_buy != r_buy) &&
                 (r_buy ? (r_rd_price <= r_limit) : (r_rd_price >= r_limit));
        if (!r_bfound) begin
            w_better = 1'b1;
        end else if (r_rd_price != r_bprice) begin
            w_better = r_buy ? (r_rd_price < r_bprice) : (r_rd_price > r_bprice);
        end else begin
            w_better = (w_age > r_bage);
        end
    end

    // fill arithmetic
    assign w_q          = (r_rem < r_bqty) ? r_rem : r_bqty;
    assign w_new_rem    = r_rem - w_q;
    assign w_maker_left = r_bqty - w_q;

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    assign w_fill_we = (r_state == S_FILL) && r_bfound && w_can_emit;
    assign w_rest_we = (r_state == S_DONE) && w_can_emit && (r_rem != '0) && w_free_found;

    // slot payload memory, read at scan index
    always_ff @(posedge i_clk) begin
        r_rd_buy   <= m_buy[r_idx[IW-1:0]];
        r_rd_price <= m_price[r_idx[IW-1:0]];
        r_rd_qty   <= m_qty[r_idx[IW-1:0]];
        r_rd_id    <= m_id[r_idx[IW-1:0]];
        r_rd_arr   <= m_arr[r_idx[IW-1:0]];
        r_rd_valid <= r_valid[r_idx[IW-1:0]];
        r_cidx     <= r_idx[IW-1:0];
        if (w_fill_we) begin
            m_qty[r_bidx] <= w_maker_left;
        end
        if (w_rest_we) begin
            m_buy[w_free_idx]   <= r_buy;
            m_price[w_free_idx] <= r_limit;
            m_qty[w_free_idx]   <= r_rem;
            m_id[w_free_idx]    <= r_tid;
            m_arr[w_free_idx]   <= r_arr_cnt;
        end
    end

    // taker and best-maker payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_buy   <= i_head.is_buy;
            r_limit <= i_head.limit_price;
            r_rem   <= i_head.order_qty;
            r_tid   <= i_head.order_id;
        end
        if (w_fill_we) begin
            r_rem <= w_new_rem;
        end
        if (r_state == S_SCAN && r_cv && w_cand && w_better) begin
            r_bidx   <= r_cidx;
            r_bprice <= r_rd_price;
            r_bage   <= w_age;
            r_bqty   <= r_rd_qty;
            r_bid    <= r_rd_id;
        end
    end

    // control: state, scan counter, valid bits, arrival counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cv      <= 1'b0;
            r_bfound  <= 1'b0;
            r_arr_cnt <= '0;
            for (int i = 0; i < ORDER_SLOTS; i++) r_valid[i] <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_cv     <= 1'b0;
                    r_bfound <= 1'b0;
                    if (i_head_valid) begin
                        r_state <= i_head.zero_qty ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx != LastCnt) begin
                        r_idx <= r_idx + CW'(1);
                        r_cv  <= 1'b1;
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (r_cv && w_cand) r_bfound <= 1'b1;
                    if (r_idx == LastCnt && !r_cv) r_state <= S_FILL;
                end
                S_FILL: begin
                    if (!r_bfound) begin
                        r_state <= S_DONE;
                    end else if (w_can_emit) begin
                        if (w_maker_left == '0) r_valid[r_bidx] <= 1'b0;
                        r_idx    <= '0;
                        r_cv     <= 1'b0;
                        r_bfound <= 1'b0;
                        r_state  <= (w_new_rem != '0) ? S_SCAN : S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_can_emit) begin
                        if (w_rest_we) begin
                            r_valid[w_free_idx] <= 1'b1;
                            r_arr_cnt <= r_arr_cnt + FieldWidth'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fill_we || (r_state == S_DONE && w_can_emit)) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            r_o_taker   <= r_tid;
            r_o_maker   <= r_bid;
            r_o_price   <= r_bprice;
            r_o_qty     <= w_q;
            r_o_rem     <= w_new_rem;
            r_o_rested  <= 1'b0;
            r_o_dropped <= 1'b0;
            r_o_last    <= 1'b0;
        end else if (r_state == S_DONE && w_can_emit) begin
            r_o_taker   <= r_tid;
            r_o_maker   <= '0;
            r_o_price   <= '0;
            r_o_qty     <= '0;
            r_o_rem     <= r_rem;
            r_o_rested  <= w_rest_we;
            r_o_dropped <= (r_rem != '0) && !w_free_found;
            r_o_last    <= 1'b1;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_taker_id      = r_o_taker;
    assign o_maker_id      = r_o_maker;
    assign o_fill_price    = r_o_price;
    assign o_fill_qty      = r_o_qty;
    assign o_remaining_qty = r_o_rem;
    assign o_rested        = r_o_rested;
    assign o_dropped       = r_o_dropped;
    assign o_last          = r_o_last;

endmodule

[src/limit_order_matcher_top.sv]
// ----------------------------------------------------------------------------
// limit_order_matcher_top
// Price-time priority limit order matcher with a bounded slot table.
// ----------------------------------------------------------------------------
// Orders enter a two-entry queue and are matched one at a time. Each fill
// costs one scan of the slot table, one slot a cycle through the table's
// single read port, then a fill step. An order left with a remainder ends
// with a last scan that finds no further maker; a zero-quantity order skips
// the scan. Output stalls hold the fill and summary steps. Fill beats come
// first, then one summary beat with last set.
module limit_order_matcher_top import lom_pkg::*; #(
    parameter int unsigned ORDER_SLOTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_is_buy,
    input  logic [FieldWidth-1:0] i_limit_price,
    input  logic [FieldWidth-1:0] i_order_qty,
    input  logic [FieldWidth-1:0] i_order_id,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FieldWidth-1:0] o_taker_id,
    output logic [FieldWidth-1:0] o_maker_id,
    output logic [FieldWidth-1:0] o_fill_price,
    output logic [FieldWidth-1:0] o_fill_qty,
    output logic [FieldWidth-1:0] o_remaining_qty,
    output logic                  o_rested,
    output logic                  o_dropped,
    output logic                  o_last
);

    t_order w_head;
    logic   w_head_valid;
    logic   w_pop;

    // order queue
    lom_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_is_buy      (i_is_buy),
        .i_limit_price (i_limit_price),
        .i_order_qty   (i_order_qty),
        .i_order_id    (i_order_id),
        .i_pop         (w_pop),
        .o_head_valid  (w_head_valid),
        .o_head        (w_head)
    );

    // matching engine
    lom_back #(.ORDER_SLOTS(ORDER_SLOTS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_taker_id      (o_taker_id),
        .o_maker_id      (o_maker_id),
        .o_fill_price    (o_fill_price),
        .o_fill_qty      (o_fill_qty),
        .o_remaining_qty (o_remaining_qty),
        .o_rested        (o_rested),
        .o_dropped       (o_dropped),
        .o_last          (o_last)
    );

    // summary beats never both rest and drop
    a_rest_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_rested && o_dropped))
        else $error("rested and dropped together");

    // a fill beat always trades something
    a_fill_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_fill_qty != '0 && !o_rested && !o_dropped))
        else $error("empty fill beat");

    // summary beat carries no fill
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_fill_qty == '0 && o_maker_id == '0))
        else $error("summary beat carries fill data");

    // a drop or a rest only happens with a remainder
    a_drop_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_dropped || o_rested)) |-> (o_remaining_qty != '0))
        else $error("rest or drop without remainder");

endmodule

[test/limit_order_matcher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// limit_order_matcher_top_tb
// Self-checking bench for the price-time priority order matcher.
// ----------------------------------------------------------------------------
// Orders are queued by an initial block and driven beat by beat with random
// gaps. A behavioural book model predicts every fill and summary beat. The
// monitor compares each output beat with the oldest prediction, under random
// stalls.
module limit_order_matcher_top_tb;
    import lom_pkg::*;

    localparam int Slots      = 32;
    localparam int WatchLimit = 40000;

    typedef struct {
        logic                  is_buy;
        logic [FieldWidth-1:0] price;
        logic [FieldWidth-1:0] qty;
        logic [FieldWidth-1:0] id;
    } t_tb_order;

    typedef struct {
        logic [FieldWidth-1:0] taker_id;
        logic [FieldWidth-1:0] maker_id;
        logic [FieldWidth-1:0] fill_price;
        logic [FieldWidth-1:0] fill_qty;
        logic [FieldWidth-1:0] remaining_qty;
        logic                  rested;
        logic                  dropped;
        logic                  last;
    } t_trade;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_is_buy = 1'b0;
    logic [FieldWidth-1:0] i_limit_price = '0;
    logic [FieldWidth-1:0] i_order_qty = '0;
    logic [FieldWidth-1:0] i_order_id = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [FieldWidth-1:0] o_taker_id;
    logic [FieldWidth-1:0] o_maker_id;
    logic [FieldWidth-1:0] o_fill_price;
    logic [FieldWidth-1:0] o_fill_qty;
    logic [FieldWidth-1:0] o_remaining_qty;
    logic                  o_rested;
    logic                  o_dropped;
    logic                  o_last;

    // book model
    logic                  book_valid [Slots];
    logic                  book_buy   [Slots];
    logic [FieldWidth-1:0] book_price [Slots];
    logic [FieldWidth-1:0] book_qty   [Slots];
    logic [FieldWidth-1:0] book_id    [Slots];
    logic [FieldWidth-1:0] book_seq   [Slots];
    logic [FieldWidth-1:0] seq_count;

    t_tb_order pending_orders[$];
    t_trade    expected_trades[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;
    bit        stim_done = 1'b0;

    limit_order_matcher_top #(.ORDER_SLOTS(Slots)) uut (.*);

    always #6 i_clk = ~i_clk;

    // best opposite-side maker, or -1
    function automatic int find_maker(logic buy, logic [FieldWidth-1:0] lim);
        int                    best;
        logic [FieldWidth-1:0] bp;
        logic [FieldWidth-1:0] ba;
        logic [FieldWidth-1:0] age;
        bit                    better;
        best = -1;
        bp = '0;
        ba = '0;
        for (int i = 0; i < Slots; i++) begin
            if (!book_valid[i] || book_buy[i] == buy) continue;
            if (buy ? (book_price[i] > lim) : (book_price[i] < lim)) continue;
            age = seq_count - book_seq[i];
            if (best < 0) better = 1'b1;
            else if (book_price[i] != bp)
                better = buy ? (book_price[i] < bp) : (book_price[i] > bp);
            else better = age > ba;
            if (better) begin
                best = i;
                bp = book_price[i];
                ba = age;
            end
        end
        return best;
    endfunction

    // match one order against the book and queue its beats
    task automatic match_order(t_tb_order o);
        logic [FieldWidth-1:0] left;
        logic [FieldWidth-1:0] q;
        int                    m;
        int                    f;
        t_trade                t;
        left = o.qty;
        while (left != 0) begin
            m = find_maker(o.is_buy, o.price);
            if (m < 0) break;
            q = (left < book_qty[m]) ? left : book_qty[m];
            left -= q;
            book_qty[m] -= q;
            t = '{o.id, book_id[m], book_price[m], q, left, 1'b0, 1'b0, 1'b0};
            expected_trades.insert(expected_trades.size(), t);
            if (book_qty[m] == 0) book_valid[m] = 1'b0;
        end
        t = '{o.id, '0, '0, '0, left, 1'b0, 1'b0, 1'b1};
        if (left != 0) begin
            f = -1;
            for (int i = 0; i < Slots; i++)
                if (!book_valid[i] && f < 0) f = i;
            if (f >= 0) begin
                book_valid[f] = 1'b1;
                book_buy[f] = o.is_buy;
                book_price[f] = o.price;
                book_qty[f] = left;
                book_id[f] = o.id;
                book_seq[f] = seq_count;
                seq_count += 1;
                t.rested = 1'b1;
            end else begin
                t.dropped = 1'b1;
            end
        end
        expected_trades.insert(expected_trades.size(), t);
    endtask

    function automatic void add_order(logic b, logic [31:0] p, logic [31:0] q,
                                      logic [31:0] id);
        t_tb_order o;
        o = '{b, p, q, id};
        pending_orders.insert(pending_orders.size(), o);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (pending_orders.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
                    t_tb_order o;
                    o = pending_orders[0];
                    pending_orders.delete(0);
                    i_in_valid    <= 1'b1;
                    i_is_buy      <= o.is_buy;
                    i_limit_price <= o.price;
                    i_order_qty   <= o.qty;
                    i_order_id    <= o.id;
                    match_order(o);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_trades.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected beat taker %0d maker %0d", o_taker_id,
                                 o_maker_id);
                end else begin
                    t_trade e;
                    e = expected_trades[0];
                    expected_trades.delete(0);
                    if (e.taker_id !== o_taker_id || e.maker_id !== o_maker_id ||
                        e.fill_price !== o_fill_price || e.fill_qty !== o_fill_qty ||
                        e.remaining_qty !== o_remaining_qty || e.rested !== o_rested ||
                        e.dropped !== o_dropped || e.last !== o_last) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp %0d/%0d/%0d/%0d/%0d/%b%b%b got %0d/%0d/%0d/%0d/%0d/%b%b%b",
                                     e.taker_id, e.maker_id, e.fill_price, e.fill_qty,
                                     e.remaining_qty, e.rested, e.dropped, e.last,
                                     o_taker_id, o_maker_id, o_fill_price, o_fill_qty,
                                     o_remaining_qty, o_rested, o_dropped, o_last);
                    end
                end
            end
        end
    end

    initial begin
        int          n;
        logic [31:0] base;
        for (int i = 0; i < Slots; i++) book_valid[i] = 1'b0;
        seq_count = '0;
        // directed: extremes, zero quantity, priority ties, full book
        add_order(1'b1, 32'd100, 32'd0, 32'hFFFF_FFFF);
        add_order(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        add_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
        add_order(1'b1, 32'd0, 32'd5, 32'd3);
        add_order(1'b0, 32'd0, 32'd2, 32'd4);
        add_order(1'b0, 32'd10, 32'd3, 32'd5);
        add_order(1'b0, 32'd10, 32'd3, 32'd6);
        add_order(1'b0, 32'd9, 32'd1, 32'd7);
        add_order(1'b1, 32'd10, 32'd6, 32'd8);
        add_order(1'b1, 32'd10, 32'd0, 32'd0);
        for (int i = 0; i < 34; i++) add_order(1'b1, 32'd1, 32'd1, 32'd100 + i);
        add_order(1'b0, 32'd0, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        n = 0;
        // random: mostly crossing orders around a mid price of 1000 to 1020
        while (n < 435) begin
            base = $urandom_range(3) == 0 ? $urandom : 32'd1000 + $urandom_range(20);
            if ($urandom_range(9) == 0) quiet = 1'b0;
            case ($urandom_range(9))
                0: add_order(1'($urandom_range(1)), $urandom, $urandom, $urandom);
                1: add_order(1'($urandom_range(1)), base, 32'd0, $urandom);
                2: add_order(1'($urandom_range(1)), base, $urandom_range(200) + 100,
                             $urandom);
                default: add_order(1'($urandom_range(1)), base, $urandom_range(20) + 1,
                                   $urandom);
            endcase
            n++;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // long stretch without idling partway through
        wait (pending_orders.size() < 300);
        quiet = 1'b1;
        wait (pending_orders.size() < 200);
        quiet = 1'b0;
        wait (pending_orders.size() == 0);
        @(posedge i_clk);
        while (i_in_valid && o_in_stall) @(posedge i_clk);
        wait (expected_trades.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_trades.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
